>>> hw/rtl/fbcc_pkg.sv
// fbcc_pkg: shared constants and types for the frustum box corner cull block
// plane coefficient layout, arithmetic widths and queue sizing
// no dependencies
package fbcc_pkg;

	localparam int CORNERS_PER_BOX = 8;
	localparam int CIDX_W = (CORNERS_PER_BOX > 1) ? $clog2(CORNERS_PER_BOX) : 1;

	localparam int PLANE_COUNT = 6;
	localparam int PIDX_W = $clog2(PLANE_COUNT);
	localparam int CFG_W = 64;

	localparam int COORD_W = 16;
	localparam int COEF_W = 16;
	localparam int PROD_W = COORD_W + COEF_W;
	localparam int ACC_W = PROD_W + 2;
	localparam int D_SHIFT = 14;
	localparam int AXES = 3;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic signed [COEF_W-1:0] d;
		logic signed [COEF_W-1:0] nz;
		logic signed [COEF_W-1:0] ny;
		logic signed [COEF_W-1:0] nx;
	} plane_t;

	// front to queue write side
	typedef struct packed {
		logic push;
		logic hit;
	} qwr_t;

	// queue to back read side
	typedef struct packed {
		logic empty;
		logic hit;
	} qrd_t;

endpackage

>>> hw/rtl/fbcc_front.sv
// fbcc_front: accepts corners and classifies each one against the six planes
// stage one forms eighteen products, stage two sums, offsets and compares
// depends on fbcc_pkg
module fbcc_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  fbcc_pkg::plane_t                      planes [fbcc_pkg::PLANE_COUNT],
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [fbcc_pkg::COORD_W-1:0]   corner_x,
	input  logic signed [fbcc_pkg::COORD_W-1:0]   corner_y,
	input  logic signed [fbcc_pkg::COORD_W-1:0]   corner_z,
	input  logic                                  q_full,
	output fbcc_pkg::qwr_t                        qwr
);

	logic                                  adv;
	logic                                  v_s1;
	logic                                  v_s2;
	logic                                  inside_s2;
	logic signed [fbcc_pkg::PROD_W-1:0]    prod_s1 [fbcc_pkg::PLANE_COUNT][fbcc_pkg::AXES];
	logic signed [fbcc_pkg::ACC_W-1:0]     acc [fbcc_pkg::PLANE_COUNT];
	logic                                  inside_c;

	// pipeline moves unless the last stage holds a beat the queue cannot take
	assign adv      = !v_s2 || !q_full;
	assign in_ready = adv;

	assign qwr.push = v_s2 && !q_full;
	assign qwr.hit  = inside_s2;

	always_comb begin
		inside_c = 1'b1;
		for (int p = 0; p < fbcc_pkg::PLANE_COUNT; p++) begin
			acc[p] = fbcc_pkg::ACC_W'(prod_s1[p][0])
				+ fbcc_pkg::ACC_W'(prod_s1[p][1])
				+ fbcc_pkg::ACC_W'(prod_s1[p][2])
				+ (fbcc_pkg::ACC_W'(planes[p].d) <<< fbcc_pkg::D_SHIFT);
			if (!(acc[p] > fbcc_pkg::ACC_W'(0))) begin
				inside_c = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int p = 0; p < fbcc_pkg::PLANE_COUNT; p++) begin
				prod_s1[p][0] <= planes[p].nx * corner_x;
				prod_s1[p][1] <= planes[p].ny * corner_y;
				prod_s1[p][2] <= planes[p].nz * corner_z;
			end
			inside_s2 <= inside_c;
		end
	end

endmodule

>>> hw/rtl/fbcc_queue.sv
// fbcc_queue: short queue of corner classifications between front and back
// one bit per entry, combinational read of the head entry
// depends on fbcc_pkg
module fbcc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  fbcc_pkg::qwr_t  qwr,
	output logic            full,
	input  logic            pop,
	output fbcc_pkg::qrd_t  qrd
);

	logic [fbcc_pkg::QUEUE_DEPTH-1:0] mem_q;
	logic [fbcc_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [fbcc_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [fbcc_pkg::QCNT_W-1:0]      count_q;

	assign full      = (count_q == fbcc_pkg::QCNT_W'(fbcc_pkg::QUEUE_DEPTH));
	assign qrd.empty = (count_q == '0);
	assign qrd.hit   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (qwr.push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (qwr.push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !qwr.push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (qwr.push) begin
			mem_q[wr_ptr_q] <= qwr.hit;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(qwr.push && full))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && qrd.empty))
		else $error("queue read while empty");

endmodule

>>> hw/rtl/fbcc_back.sv
// fbcc_back: folds corner classifications into one visibility beat per box
// corner counter, running any-inside flag and output register
// depends on fbcc_pkg
module fbcc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  fbcc_pkg::qrd_t  qrd,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            box_visible
);

	logic [fbcc_pkg::CIDX_W-1:0] cnt_q;
	logic                        any_q;
	logic                        out_valid_q;
	logic                        box_visible_q;
	logic                        last;

	assign last        = (cnt_q == fbcc_pkg::CIDX_W'(fbcc_pkg::CORNERS_PER_BOX - 1));
	assign pop         = !qrd.empty && (!last || !out_valid_q || out_ready);
	assign out_valid   = out_valid_q;
	assign box_visible = box_visible_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			any_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && last) begin
				cnt_q       <= '0;
				any_q       <= 1'b0;
				out_valid_q <= 1'b1;
			end else begin
				if (pop) begin
					cnt_q <= cnt_q + 1'b1;
					any_q <= any_q | qrd.hit;
				end
				if (out_ready) begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && last) begin
			box_visible_q <= any_q | qrd.hit;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= fbcc_pkg::CIDX_W'(fbcc_pkg::CORNERS_PER_BOX - 1))
		else $error("corner counter out of range");

	a_box_close: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && last) |=> (out_valid_q && cnt_q == '0 && !any_q))
		else $error("box not closed after last corner");

endmodule

>>> hw/rtl/frustum_box_corner_cull.sv
// Frustum box culling: takes the corners of a box one beat per cycle, unless a full queue
// stalls the front, and emits one visibility beat after every CORNERS_PER_BOX corners.
// A corner is inside when nx*x + ny*y + nz*z + d*2^14 is strictly positive for all six
// planes; box_visible is 1 when any corner of the box was inside. The rate is set by the
// eighteen 16x16 multipliers of the first front stage, which work on every corner at once.
// The result beat for the last corner of a box passes the two front stages, the queue and
// the back output register before it is offered. A four-entry queue lets the front keep
// taking corners while a result waits. Plane registers are written through
// cfg_we/cfg_index/cfg_wdata; the user must write them only while no box is in flight,
// which the block does not enforce; indexes beyond the six planes are ignored.
// depends on fbcc_pkg, fbcc_front, fbcc_queue, fbcc_back
module frustum_box_corner_cull (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [fbcc_pkg::PIDX_W-1:0]           cfg_index,
	input  logic [fbcc_pkg::CFG_W-1:0]            cfg_wdata,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [fbcc_pkg::COORD_W-1:0]   corner_x,
	input  logic signed [fbcc_pkg::COORD_W-1:0]   corner_y,
	input  logic signed [fbcc_pkg::COORD_W-1:0]   corner_z,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  box_visible
);

	fbcc_pkg::plane_t planes_q [fbcc_pkg::PLANE_COUNT];
	fbcc_pkg::qwr_t   qwr;
	fbcc_pkg::qrd_t   qrd;
	logic             q_full;
	logic             pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < fbcc_pkg::PLANE_COUNT; p++) begin
				planes_q[p] <= '0;
			end
		end else if (cfg_we && (cfg_index < fbcc_pkg::PIDX_W'(fbcc_pkg::PLANE_COUNT))) begin
			planes_q[cfg_index] <= fbcc_pkg::plane_t'(cfg_wdata);
		end
	end

	fbcc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.planes   (planes_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.corner_x (corner_x),
		.corner_y (corner_y),
		.corner_z (corner_z),
		.q_full   (q_full),
		.qwr      (qwr)
	);

	fbcc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.qwr    (qwr),
		.full   (q_full),
		.pop    (pop),
		.qrd    (qrd)
	);

	fbcc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.qrd         (qrd),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.box_visible (box_visible)
	);

endmodule
